@@ hdl/cle_pkg.sv @@
// Shared constants for the gap-buffer line editor.
`timescale 1ns / 1ps
package cle_pkg;

	localparam int CAPACITY = 64;
	localparam int CHAR_W   = 8;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [CHAR_W-1:0] KEY_BACK  = 8'h2D;
	localparam logic [CHAR_W-1:0] KEY_RIGHT = 8'h3E;
	localparam logic [CHAR_W-1:0] KEY_LEFT  = 8'h3C;

	localparam logic ACT_KEY    = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

endpackage

@@ hdl/cle_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cle_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/cursor_line_editor.sv @@
// Gap-buffer line editor: two stack memories, cursor moves, backspace, insert, line dump.
//
//   channel   signals                                       flow
//   command   start, busy, action, key_byte                 in, taken when start && !busy
//   result    valid, out_char, line_end, line_empty,        out, one result per cycle in a dump,
//             overflowed                                    no back-pressure
//
// Insert and backspace finish as they are accepted; a cursor move reads one stack memory,
// then writes the other in ST_MOVE, limited by the single read port of each memory.
// A finish on an empty line gives a single result; a line of n characters is dumped in ST_EMIT,
// one memory read per character; each result appears on valid the cycle after its read.
// Reset clears the counts and the overflow flag; the memories need no clearing.
// The receiver cannot stall, so busy depends only on the editor's own sequencing.
`timescale 1ns / 1ps
module cursor_line_editor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       action,
	input  logic [cle_pkg::CHAR_W-1:0] key_byte,
	output logic                       valid,
	output logic [cle_pkg::CHAR_W-1:0] out_char,
	output logic                       line_end,
	output logic                       line_empty,
	output logic                       overflowed
);

	typedef enum logic [1:0] {ST_IDLE, ST_MOVE, ST_EMIT} state_t;

	state_t                      state_q;
	logic [cle_pkg::CNT_W-1:0]   lc_q, rc_q, total_q;
	logic [cle_pkg::ADDR_W-1:0]  idx_q;
	logic                        ovf_q;
	logic                        dir_q;     // 1: move from left stack to right stack
	logic                        valid_s1, sel_s1, last_s1, empty_s1, ovf_s1;

	logic                        accept;
	logic [cle_pkg::CNT_W:0]     total_now;
	logic                        room;
	logic                        is_last;
	logic [cle_pkg::CNT_W-1:0]   lc_dec, rc_dec, rev_idx, idx_ext;

	logic                        l_we, r_we;
	logic [cle_pkg::ADDR_W-1:0]  l_waddr, l_raddr, r_waddr, r_raddr;
	logic [cle_pkg::CHAR_W-1:0]  l_wdata, l_rdata, r_wdata, r_rdata;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign total_now = {1'b0, lc_q} + {1'b0, rc_q};
	assign room      = (total_now < (cle_pkg::CNT_W+1)'(cle_pkg::CAPACITY));
	assign idx_ext   = cle_pkg::CNT_W'(idx_q);
	assign is_last   = ((idx_ext + cle_pkg::CNT_W'(1)) == total_q);
	assign lc_dec    = lc_q - cle_pkg::CNT_W'(1);
	assign rc_dec    = rc_q - cle_pkg::CNT_W'(1);
	// right stack is dumped top-down after the left stack
	assign rev_idx   = total_q - cle_pkg::CNT_W'(1) - idx_ext;

	// left stack: insert at accept, or receive the right top on a move right
	assign l_we    = (state_q == ST_MOVE && !dir_q)
		|| (accept && action == cle_pkg::ACT_KEY && room
			&& key_byte != cle_pkg::KEY_LEFT && key_byte != cle_pkg::KEY_RIGHT
			&& key_byte != cle_pkg::KEY_BACK);
	assign l_wdata = (state_q == ST_MOVE) ? r_rdata : key_byte;
	assign l_waddr = lc_q[cle_pkg::ADDR_W-1:0];
	assign l_raddr = (state_q == ST_EMIT) ? idx_q : lc_dec[cle_pkg::ADDR_W-1:0];

	assign r_we    = (state_q == ST_MOVE) && dir_q;
	assign r_wdata = l_rdata;
	assign r_waddr = rc_q[cle_pkg::ADDR_W-1:0];
	assign r_raddr = (state_q == ST_EMIT) ? rev_idx[cle_pkg::ADDR_W-1:0]
		: rc_dec[cle_pkg::ADDR_W-1:0];

	cle_ram #(.WIDTH(cle_pkg::CHAR_W), .DEPTH(cle_pkg::CAPACITY)) u_left_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	cle_ram #(.WIDTH(cle_pkg::CHAR_W), .DEPTH(cle_pkg::CAPACITY)) u_right_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (r_wdata),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			lc_q     <= '0;
			rc_q     <= '0;
			total_q  <= '0;
			idx_q    <= '0;
			ovf_q    <= 1'b0;
			dir_q    <= 1'b0;
			valid_s1 <= 1'b0;
			sel_s1   <= 1'b0;
			last_s1  <= 1'b0;
			empty_s1 <= 1'b0;
			ovf_s1   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					valid_s1 <= accept && action == cle_pkg::ACT_FINISH && total_now == '0;
					if (accept) begin
						if (action == cle_pkg::ACT_FINISH) begin
							if (total_now == '0) begin
								last_s1  <= 1'b1;
								empty_s1 <= 1'b1;
								ovf_s1   <= ovf_q;
								ovf_q    <= 1'b0;
							end else begin
								state_q <= ST_EMIT;
								idx_q   <= '0;
								total_q <= total_now[cle_pkg::CNT_W-1:0];
							end
						end else begin
							case (key_byte)
								cle_pkg::KEY_LEFT: begin
									if (lc_q != '0) begin
										state_q <= ST_MOVE;
										dir_q   <= 1'b1;
										lc_q    <= lc_dec;
									end
								end
								cle_pkg::KEY_RIGHT: begin
									if (rc_q != '0) begin
										state_q <= ST_MOVE;
										dir_q   <= 1'b0;
										rc_q    <= rc_dec;
									end
								end
								cle_pkg::KEY_BACK: begin
									if (lc_q != '0) begin
										lc_q <= lc_dec;
									end
								end
								default: begin
									if (room) begin
										lc_q <= lc_q + cle_pkg::CNT_W'(1);
									end else begin
										ovf_q <= 1'b1;
									end
								end
							endcase
						end
					end
				end
				ST_MOVE: begin
					valid_s1 <= 1'b0;
					// read data is back: the write happens this cycle
					if (dir_q) begin
						rc_q <= rc_q + cle_pkg::CNT_W'(1);
					end else begin
						lc_q <= lc_q + cle_pkg::CNT_W'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_EMIT: begin
					valid_s1 <= 1'b1;
					sel_s1   <= (idx_ext < lc_q);
					last_s1  <= is_last;
					empty_s1 <= 1'b0;
					ovf_s1   <= ovf_q;
					idx_q    <= idx_q + cle_pkg::ADDR_W'(1);
					if (is_last) begin
						state_q <= ST_IDLE;
						lc_q    <= '0;
						rc_q    <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					valid_s1 <= 1'b0;
					state_q  <= ST_IDLE;
				end
			endcase
		end
	end

	assign valid      = valid_s1;
	assign out_char   = empty_s1 ? '0 : (sel_s1 ? l_rdata : r_rdata);
	assign line_end   = last_s1;
	assign line_empty = empty_s1;
	assign overflowed = ovf_s1;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, lc_q} + {1'b0, rc_q}) <= (cle_pkg::CNT_W+1)'(cle_pkg::CAPACITY))
		else $error("stack depths exceed capacity");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(state_q == ST_EMIT || (accept && action == cle_pkg::ACT_FINISH)))
		else $error("result without a line dump");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && empty_s1) |-> last_s1)
		else $error("empty line result not marked last");

	a_move_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE) |=> (state_q == ST_IDLE))
		else $error("cursor move did not finish in one cycle");

endmodule

@@ bench/cursor_line_editor_tb.sv @@
// Self-checking bench for the gap-buffer line editor: random keystroke lines against a stack model.
`timescale 1ns / 1ps
module cursor_line_editor_tb;

	localparam int LINE_ITEMS  = 320;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;

	typedef logic [cle_pkg::CHAR_W-1:0] char_t;

	typedef struct packed {
		char_t ch;
		logic  last;
		logic  empty;
		logic  ovf;
	} line_char_t;

	// Two-stack copy of the editor; a finish queues the line it should dump.
	class line_scoreboard;
		char_t       left_text[cle_pkg::CAPACITY];
		char_t       right_text[cle_pkg::CAPACITY];
		int unsigned left_count;
		int unsigned right_count;
		bit          overflow_seen;
		line_char_t  line_chars[$];
		int unsigned fail_count;

		function new();
			left_count    = 0;
			right_count   = 0;
			overflow_seen = 0;
			fail_count    = 0;
		endfunction

		function void push_char(char_t ch, bit last, bit empty);
			line_char_t r;
			r.ch    = ch;
			r.last  = last;
			r.empty = empty;
			r.ovf   = overflow_seen;
			line_chars = {line_chars, r};
		endfunction

		function void take_command(logic act, char_t key);
			int unsigned total;
			int unsigned k;
			if (act == cle_pkg::ACT_KEY) begin
				if (key == cle_pkg::KEY_LEFT) begin
					if (left_count > 0 && right_count < cle_pkg::CAPACITY) begin
						left_count--;
						right_text[right_count] = left_text[left_count];
						right_count++;
					end
				end else if (key == cle_pkg::KEY_RIGHT) begin
					if (right_count > 0 && left_count < cle_pkg::CAPACITY) begin
						right_count--;
						left_text[left_count] = right_text[right_count];
						left_count++;
					end
				end else if (key == cle_pkg::KEY_BACK) begin
					if (left_count > 0)
						left_count--;
				end else if (left_count + right_count < cle_pkg::CAPACITY) begin
					left_text[left_count] = key;
					left_count++;
				end else begin
					overflow_seen = 1'b1;
				end
			end else begin
				total = left_count + right_count;
				k = 0;
				if (total == 0) begin
					push_char('0, 1'b1, 1'b1);
				end else begin
					for (int i = 0; i < left_count; i++) begin
						push_char(left_text[i], k + 1 == total, 1'b0);
						k++;
					end
					for (int i = right_count; i > 0; i--) begin
						push_char(right_text[i-1], k + 1 == total, 1'b0);
						k++;
					end
				end
				left_count    = 0;
				right_count   = 0;
				overflow_seen = 1'b0;
			end
		endfunction

		function void check_char(line_char_t got);
			line_char_t want;
			if (line_chars.size() == 0) begin
				if (fail_count < MAX_REPORTS)
					$display("%0t: unexpected result char=%h end=%b empty=%b ovf=%b",
						$time, got.ch, got.last, got.empty, got.ovf);
				fail_count++;
				return;
			end
			want = line_chars[0];
			line_chars.delete(0);
			if (got !== want) begin
				if (fail_count < MAX_REPORTS)
					$display("%0t: mismatch char=%h/%h end=%b/%b empty=%b/%b ovf=%b/%b (exp/act)",
						$time, want.ch, got.ch, want.last, got.last,
						want.empty, got.empty, want.ovf, got.ovf);
				fail_count++;
			end
		endfunction

		function int unsigned pending();
			return line_chars.size();
		endfunction
	endclass

	logic  clk;
	logic  arst_n   = 1'b0;
	logic  start    = 1'b0;
	logic  action   = cle_pkg::ACT_KEY;
	char_t key_byte = '0;
	logic  busy;
	logic  valid;
	char_t out_char;
	logic  line_end;
	logic  line_empty;
	logic  overflowed;

	line_scoreboard sb = new();
	int unsigned    cycle_count = 0;
	int unsigned    items_sent  = 0;
	bit             gaps_on     = 1'b1;

	cursor_line_editor dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.key_byte   (key_byte),
		.valid      (valid),
		.out_char   (out_char),
		.line_end   (line_end),
		.line_empty (line_empty),
		.overflowed (overflowed)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && valid)
			sb.check_char({out_char, line_end, line_empty, overflowed});
	end

	// Hold start high until the editor takes the transaction.
	task automatic send_command(logic act, char_t key);
		if (gaps_on && $urandom_range(99) < 14) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start    <= 1'b1;
		action   <= act;
		key_byte <= key;
		do @(posedge clk); while (busy);
		sb.take_command(act, key);
		items_sent++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic char_t pick_key();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 18) return cle_pkg::KEY_LEFT;
		if (r < 32) return cle_pkg::KEY_RIGHT;
		if (r < 42) return cle_pkg::KEY_BACK;
		return char_t'($urandom_range(255));
	endfunction

	initial begin
		int unsigned line_no;
		int unsigned kind;
		int unsigned n;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty line, edge moves and backspace at line start
		send_command(cle_pkg::ACT_FINISH, 8'hFF);
		send_command(cle_pkg::ACT_KEY, cle_pkg::KEY_LEFT);
		send_command(cle_pkg::ACT_KEY, cle_pkg::KEY_RIGHT);
		send_command(cle_pkg::ACT_KEY, cle_pkg::KEY_BACK);
		send_command(cle_pkg::ACT_FINISH, 8'h00);
		// extreme bytes, moves both ways, backspace in the middle
		send_command(cle_pkg::ACT_KEY, 8'h00);
		send_command(cle_pkg::ACT_KEY, 8'hFF);
		send_command(cle_pkg::ACT_KEY, 8'h41);
		send_command(cle_pkg::ACT_KEY, cle_pkg::KEY_LEFT);
		send_command(cle_pkg::ACT_KEY, cle_pkg::KEY_LEFT);
		send_command(cle_pkg::ACT_KEY, 8'h7F);
		send_command(cle_pkg::ACT_KEY, cle_pkg::KEY_RIGHT);
		send_command(cle_pkg::ACT_KEY, cle_pkg::KEY_BACK);
		send_command(cle_pkg::ACT_KEY, cle_pkg::KEY_LEFT);
		send_command(cle_pkg::ACT_KEY, cle_pkg::KEY_LEFT);
		send_command(cle_pkg::ACT_KEY, cle_pkg::KEY_LEFT);
		send_command(cle_pkg::ACT_KEY, cle_pkg::KEY_LEFT);
		send_command(cle_pkg::ACT_KEY, cle_pkg::KEY_BACK);
		send_command(cle_pkg::ACT_KEY, 8'h80);
		send_command(cle_pkg::ACT_KEY, cle_pkg::KEY_RIGHT);
		send_command(cle_pkg::ACT_KEY, cle_pkg::KEY_RIGHT);
		send_command(cle_pkg::ACT_KEY, cle_pkg::KEY_RIGHT);
		send_command(cle_pkg::ACT_FINISH, 8'h55);
		wait_drained();

		line_no = 0;
		while (items_sent < LINE_ITEMS) begin
			gaps_on = !(line_no >= 8 && line_no < 20);
			kind = $urandom_range(99);
			if (line_no == 3 || line_no == 25 || kind < 6) begin
				// send more keystrokes than the capacity, mostly inserts, so inserts may be dropped
				n = cle_pkg::CAPACITY + $urandom_range(1, 8);
				repeat (n) begin
					if ($urandom_range(99) < 12)
						send_command(cle_pkg::ACT_KEY,
							$urandom_range(1) ? cle_pkg::KEY_LEFT : cle_pkg::KEY_RIGHT);
					else
						send_command(cle_pkg::ACT_KEY, char_t'($urandom_range(255)));
				end
				repeat ($urandom_range(0, 4)) send_command(cle_pkg::ACT_KEY, pick_key());
			end else if (kind < 88) begin
				repeat ($urandom_range(0, 24)) send_command(cle_pkg::ACT_KEY, pick_key());
			end else begin
				// backspace and left moves only, often on an empty line
				repeat ($urandom_range(0, 4))
					send_command(cle_pkg::ACT_KEY,
						$urandom_range(1) ? cle_pkg::KEY_BACK : cle_pkg::KEY_LEFT);
			end
			send_command(cle_pkg::ACT_FINISH, char_t'($urandom_range(255)));
			if (line_no == 12)
				wait_drained();
			line_no++;
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.fail_count == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
